[design/gs_pkg.sv]
// ----------------------------------------------------------------------------
// gs_pkg: shared types and constants of the Gauss-Seidel solver
// Sizes, opcodes, status codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package gs_pkg;

	// Built size of the system and width of one stored value.
	localparam int MaxUnknowns = 8;
	localparam int ValW        = 32;
	localparam int FracW       = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_LIMIT     = 2'd1;
	localparam logic [1:0] ST_ZERO_DIAG = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_TOL   = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIAG_RD,
		S_DIAG_CHK,
		S_ROW_START,
		S_TERM_RD,
		S_TERM_MUL,
		S_TERM_ACC,
		S_DIV_START,
		S_DIV_WAIT,
		S_UPDATE,
		S_SWEEP_END,
		S_EMIT
	} state_t;

endpackage

[design/gauss_seidel_solver.sv]
// ----------------------------------------------------------------------------
// gauss_seidel_solver: iterative Gauss-Seidel linear system solver
// Loads an augmented matrix word by word, then sweeps in place until the
// changes fall within tolerance or the sweep limit is reached; a zero diagonal ends the solve before any sweep.
// ----------------------------------------------------------------------------
//  channel | signals                                             | direction
//  in      | in_valid, in_stall, opcode, row_index, column_index,| into block
//          | coefficient                                         |
//  out     | out_valid, out_stall, unknown_index, solution_value,| out of block
//          | status, sweeps_done, last                           |
//  cfg     | cfg_we, cfg_index, cfg_data                         | into block
//
// Load words are written into the store while idle. A solve checks each diagonal
// entry, then sweeps row by row: read the constant, read, multiply and subtract
// each off-diagonal term on the shared multiplier, capture the diagonal, run the
// bit-serial divide of the 56-bit dividend and update the unknown, then close the
// sweep. Results are emitted in order, advancing while out_stall is low.
// Reset clears control state; the matrix store is undefined until written.
// in_stall stays high for the whole solve and while results are emitted;
// out_stall holds the current result word.
module gauss_seidel_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [2:0]  row_index,
	input  logic [3:0]  column_index,
	input  logic signed [31:0] coefficient,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  unknown_index,
	output logic signed [31:0] solution_value,
	output logic [1:0]  status,
	output logic [15:0] sweeps_done,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	// Data width used in arithmetic is capped at the 32-bit ports.
	localparam int DW     = (gs_pkg::ValW < 32) ? gs_pkg::ValW : 32;
	localparam int MaxN   = gs_pkg::MaxUnknowns;
	localparam int Stride = MaxN + 1;
	localparam int Depth  = MaxN * Stride;
	localparam int AddrW  = $clog2(Depth);
	localparam int IdxW   = $clog2(MaxN);
	localparam int CntW   = $clog2(MaxN + 1);
	localparam int SumW   = DW + 8;
	localparam int NumW   = SumW + gs_pkg::FracW;
	localparam logic signed [DW-1:0] Hi = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] Lo = {1'b1, {(DW-1){1'b0}}};

	gs_pkg::state_t state_q, state_d;

	logic [3:0]  count_q;
	logic [30:0] tol_q;
	logic [15:0] limit_q;

	// Matrix store, one write and one registered read port.
	logic signed [DW-1:0] mem [Depth];
	logic signed [DW-1:0] rd_q;
	logic [AddrW-1:0]     rd_addr;
	logic                 mem_we;
	logic [AddrW-1:0]     wr_addr;

	logic signed [DW-1:0] x_q [MaxN];
	logic [CntW-1:0] n_q;
	logic [IdxW-1:0] i_q, j_q, k_q;
	logic [15:0]     sweep_q, lim_q;
	logic            chg_q, sat_q, zd_q;
	logic signed [SumW-1:0] sum_q;
	logic signed [DW-1:0]   diag_q;
	logic signed [2*DW-1:0] prod_s1;
	logic signed [2*DW-gs_pkg::FracW-1:0] pf;
	logic signed [DW-1:0] pf_sat;
	logic pf_hit;

	logic div_start, div_busy;
	logic signed [NumW-1:0] div_q;
	logic signed [DW-1:0] q_sat;
	logic q_hit;
	logic signed [DW:0] diff;
	logic [DW:0] adiff;
	logic [CntW-1:0] n_clamp;

	gs_divider #(.NumW(NumW), .DenW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({sum_q, 16'd0}), .den(diag_q),
		.busy(div_busy), .quot(div_q)
	);

	always_comb begin
		if (count_q < 4'd2) n_clamp = CntW'(2);
		else if (32'(count_q) > MaxN) n_clamp = CntW'(MaxN);
		else n_clamp = CntW'(count_q);
	end

	// Loads in range are written; everything else is ignored.
	assign wr_addr = AddrW'(32'(row_index) * Stride + 32'(column_index));
	assign mem_we  = (state_q == gs_pkg::S_IDLE) && in_valid && !in_stall
		&& (opcode == gs_pkg::OP_LOAD) && (32'(row_index) < MaxN)
		&& (32'(column_index) < Stride);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= DW'(coefficient);
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd2;
			tol_q   <= 31'd1;
			limit_q <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gs_pkg::REG_COUNT: count_q <= cfg_data[3:0];
				gs_pkg::REG_TOL:   tol_q   <= cfg_data;
				gs_pkg::REG_LIMIT: limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Floor shift of the product, then saturation.
	assign pf = prod_s1[2*DW-1:gs_pkg::FracW];
	always_comb begin
		pf_hit = 1'b0;
		pf_sat = DW'(pf);
		if (pf > (2*DW-16)'(Hi)) begin pf_sat = Hi; pf_hit = 1'b1; end
		else if (pf < (2*DW-16)'(Lo)) begin pf_sat = Lo; pf_hit = 1'b1; end
	end

	always_comb begin
		q_hit = 1'b0;
		q_sat = DW'(div_q);
		if (div_q > NumW'(Hi)) begin q_sat = Hi; q_hit = 1'b1; end
		else if (div_q < NumW'(Lo)) begin q_sat = Lo; q_hit = 1'b1; end
	end
	assign diff  = (DW+1)'(q_sat) - (DW+1)'(x_q[i_q]);
	assign adiff = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gs_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		rd_addr   = '0;
		unique case (state_q)
			gs_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && opcode == gs_pkg::OP_SOLVE) state_d = gs_pkg::S_DIAG_RD;
			end
			gs_pkg::S_DIAG_RD: begin
				rd_addr = AddrW'(32'(i_q) * Stride + 32'(i_q));
				state_d = gs_pkg::S_DIAG_CHK;
			end
			gs_pkg::S_DIAG_CHK: begin
				if (rd_q == '0) state_d = gs_pkg::S_EMIT;
				else if (32'(i_q) == 32'(n_q) - 1) state_d = gs_pkg::S_ROW_START;
				else state_d = gs_pkg::S_DIAG_RD;
			end
			gs_pkg::S_ROW_START: begin
				rd_addr = AddrW'(32'(i_q) * Stride + 32'(n_q));
				state_d = gs_pkg::S_TERM_RD;
			end
			gs_pkg::S_TERM_RD: begin
				rd_addr = AddrW'(32'(i_q) * Stride + 32'(j_q));
				if (j_q == i_q) state_d = gs_pkg::S_TERM_ACC;
				else state_d = gs_pkg::S_TERM_MUL;
			end
			gs_pkg::S_TERM_MUL: state_d = gs_pkg::S_TERM_ACC;
			gs_pkg::S_TERM_ACC: begin
				if (32'(j_q) == 32'(n_q) - 1) state_d = gs_pkg::S_DIV_START;
				else state_d = gs_pkg::S_TERM_RD;
			end
			gs_pkg::S_DIV_START: begin
				div_start = 1'b1;
				state_d = gs_pkg::S_DIV_WAIT;
			end
			gs_pkg::S_DIV_WAIT: if (!div_busy) state_d = gs_pkg::S_UPDATE;
			gs_pkg::S_UPDATE: begin
				if (32'(i_q) == 32'(n_q) - 1) state_d = gs_pkg::S_SWEEP_END;
				else state_d = gs_pkg::S_ROW_START;
			end
			gs_pkg::S_SWEEP_END: begin
				if (chg_q && sweep_q < lim_q) state_d = gs_pkg::S_ROW_START;
				else state_d = gs_pkg::S_EMIT;
			end
			gs_pkg::S_EMIT: begin
				if (!out_stall && 32'(k_q) == 32'(n_q) - 1) state_d = gs_pkg::S_IDLE;
			end
			default: state_d = gs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CntW'(2); i_q <= '0; j_q <= '0; k_q <= '0;
			sweep_q <= '0; lim_q <= 16'd1; chg_q <= 1'b0; sat_q <= 1'b0; zd_q <= 1'b0;
			for (int m = 0; m < MaxN; m++) x_q[m] <= '0;
		end else begin
			unique case (state_q)
				gs_pkg::S_IDLE: if (in_valid && opcode == gs_pkg::OP_SOLVE) begin
					n_q <= n_clamp;
					lim_q <= (limit_q == '0) ? 16'd1 : limit_q;
					i_q <= '0; k_q <= '0; sweep_q <= '0;
					chg_q <= 1'b0; sat_q <= 1'b0; zd_q <= 1'b0;
					for (int m = 0; m < MaxN; m++) x_q[m] <= '0;
				end
				gs_pkg::S_DIAG_CHK: begin
					if (rd_q == '0) zd_q <= 1'b1;
					if (32'(i_q) == 32'(n_q) - 1 || rd_q == '0) begin
						i_q <= '0;
						sweep_q <= (rd_q == '0) ? 16'd0 : 16'd1;
					end else i_q <= i_q + 1'b1;
				end
				gs_pkg::S_ROW_START: begin
					j_q <= '0;
					if (i_q == '0) chg_q <= 1'b0;
				end
				gs_pkg::S_TERM_RD: ;
				gs_pkg::S_TERM_MUL: ;
				gs_pkg::S_TERM_ACC: if (32'(j_q) != 32'(n_q) - 1) j_q <= j_q + 1'b1;
				gs_pkg::S_UPDATE: begin
					x_q[i_q] <= q_sat;
					if (q_hit) sat_q <= 1'b1;
					if (adiff > (DW+1)'(tol_q)) chg_q <= 1'b1;
					if (32'(i_q) == 32'(n_q) - 1) i_q <= '0;
					else i_q <= i_q + 1'b1;
				end
				gs_pkg::S_SWEEP_END:
					if (chg_q && sweep_q < lim_q) sweep_q <= sweep_q + 1'b1;
				gs_pkg::S_EMIT: if (!out_stall) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath: constant read, product, accumulate; diagonal captured on the way.
	always_ff @(posedge clk) begin
		if (state_q == gs_pkg::S_TERM_RD && j_q == '0) sum_q <= SumW'(rd_q);
		if (state_q == gs_pkg::S_TERM_MUL) prod_s1 <= rd_q * x_q[j_q];
		if (state_q == gs_pkg::S_TERM_ACC) begin
			if (j_q == i_q) diag_q <= rd_q;
			else sum_q <= sum_q - SumW'(pf_sat);
		end
	end

	logic sat_acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sat_acc_q <= 1'b0;
		else if (state_q == gs_pkg::S_IDLE) sat_acc_q <= 1'b0;
		else if (state_q == gs_pkg::S_TERM_ACC && j_q != i_q && pf_hit) sat_acc_q <= 1'b1;
	end

	assign out_valid      = (state_q == gs_pkg::S_EMIT);
	assign unknown_index  = 3'(k_q);
	assign solution_value = 32'(x_q[k_q]);
	assign sweeps_done    = sweep_q;
	assign last           = (32'(k_q) == 32'(n_q) - 1);
	always_comb begin
		priority if (zd_q) status = gs_pkg::ST_ZERO_DIAG;
		else if (sat_q || sat_acc_q) status = gs_pkg::ST_SATURATED;
		else if (chg_q) status = gs_pkg::ST_LIMIT;
		else status = gs_pkg::ST_CONVERGED;
	end

endmodule

[design/gs_divider.sv]
// ----------------------------------------------------------------------------
// gs_divider: restoring divider, one quotient bit per cycle
// Divides a signed dividend by a signed divisor, truncating toward zero.
// ----------------------------------------------------------------------------
module gs_divider #(
	parameter int NumW = 64,
	parameter int DenW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [NumW-1:0] num,
	input  logic signed [DenW-1:0] den,
	output logic                   busy,
	output logic signed [NumW-1:0] quot
);

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] mag_q;
	logic [DenW-1:0] den_q;
	logic [DenW:0]   rem_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   shifted;

	assign shifted = {rem_q[DenW-1:0], mag_q[NumW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign busy    = (cnt_q != '0);
	assign quot    = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NumW-1] ? NumW'(-num) : NumW'(num);
			den_q <= den[DenW-1] ? DenW'(-den) : DenW'(den);
			neg_q <= num[NumW-1] ^ den[DenW-1];
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[DenW]) begin
				rem_q <= trial;
				mag_q <= {mag_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[NumW-2:0], 1'b0};
			end
		end
	end

endmodule
